/* src/fvsr_pkg.sv */
// Shared constants and helpers for the float vector sum reduction block.
// No dependencies; imported by fvsr_fadd and float_vector_sum_reduce.
`default_nettype none
package fvsr_pkg;

  localparam int unsigned MAX_VECTORS = 16;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CFG_W       = 5;
  localparam logic [31:0] CANON_QNAN  = 32'h7FC0_0000;

  // True for any NaN bit pattern
  function automatic logic is_nan(input logic [31:0] b);
    is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

endpackage
`default_nettype wire

/* src/float_vector_sum_reduce.sv */
// Top level: element-wise binary32 vector sum with a running accumulator.
// Depends on fvsr_pkg and fvsr_fadd.
//
//  channel | ports                                | role
//  in      | in_valid, in_ready, in_value_bits    | one tensor element per transfer
//  out     | out_valid, out_ready, out_sum_bits   | one group sum per transfer
//  cfg     | cfg_wr_en, cfg_wr_data               | tensor_count write
//
// One value per cycle unless a held result is not taken; the accumulator add is combinational through fvsr_fadd.
// A group sum is registered and appears in the cycle after its last value is taken.
// rst_n is synchronous: count reg to 1, sum and count cleared, output empty.
// in_ready drops only while a held result is not taken.
`default_nettype none
module float_vector_sum_reduce (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [31:0]               in_value_bits,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [31:0]               out_sum_bits,
  input  wire logic                      cfg_wr_en,
  input  wire logic [fvsr_pkg::CFG_W-1:0] cfg_wr_data
);
  import fvsr_pkg::*;

  logic [CFG_W-1:0] tensor_count_r;
  logic [31:0]      running_sum_r, running_sum_nxt;
  logic [CNT_W-1:0] values_seen_r, values_seen_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_sum_r, out_sum_nxt;
  logic [31:0]      add_sum;
  logic             accept, count_ok, last;
  logic [CFG_W-1:0] seen_inc;

  fvsr_fadd u_fadd (
    .a   (running_sum_r),
    .b   (in_value_bits),
    .sum (add_sum)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign count_ok = (tensor_count_r != '0) &&
                    (tensor_count_r <= CFG_W'(MAX_VECTORS));
  assign seen_inc = {1'b0, values_seen_r} + CFG_W'(1);
  assign last     = (seen_inc >= tensor_count_r);

  // Advance accumulator and result register
  always_comb begin
    running_sum_nxt = running_sum_r;
    values_seen_nxt = values_seen_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_sum_nxt     = out_sum_r;
    if (accept && count_ok) begin
      running_sum_nxt = (values_seen_r == '0) ? in_value_bits : add_sum;
      if (last) begin
        values_seen_nxt = '0;
        out_valid_nxt   = 1'b1;
        out_sum_nxt     = is_nan(running_sum_nxt) ? CANON_QNAN : running_sum_nxt;
      end else begin
        values_seen_nxt = seen_inc[CNT_W-1:0];
      end
    end
  end

  // Hold state; reset sets the count reg to 1 and clears the rest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tensor_count_r <= CFG_W'(1);
      running_sum_r  <= '0;
      values_seen_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) tensor_count_r <= cfg_wr_data;
      running_sum_r <= running_sum_nxt;
      values_seen_r <= values_seen_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_sum_bits = out_sum_r;

endmodule
`default_nettype wire

/* src/fvsr_fadd.sv */
// Combinational binary32 adder, round to nearest even, subnormals kept.
// Depends on fvsr_pkg (CANON_QNAN, is_nan).
`default_nettype none
module fvsr_fadd (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] sum
);
  import fvsr_pkg::*;

  logic        a_inf, b_inf, big_is_a;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, d;
  logic [26:0] mb_x, ms_x, ms_sh;
  logic        st_sh;
  logic [27:0] s_raw;
  logic [26:0] s_al;
  logic [8:0]  e_al;
  logic [4:0]  lz;
  logic        lz_found;
  logic [8:0]  shamt;
  logic [26:0] m_n;
  logic [8:0]  e_n;
  logic [30:0] packed_v, rounded;
  logic        rnd_up;

  always_comb begin
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);

    // Order operands by magnitude
    big_is_a = (a[30:0] >= b[30:0]);
    big = big_is_a ? a : b;
    sml = big_is_a ? b : a;
    eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d   = eb - es;
    mb_x = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    ms_x = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};

    // Align smaller operand, fold shifted-out bits into sticky
    if (d >= 8'd27) begin
      ms_sh = 27'd0;
      st_sh = |ms_x;
    end else begin
      ms_sh = ms_x >> d;
      st_sh = ((ms_sh << d) != ms_x);
    end
    ms_sh[0] = ms_sh[0] | st_sh;

    // Add or subtract magnitudes
    if (big[31] == sml[31]) s_raw = {1'b0, mb_x} + {1'b0, ms_sh};
    else                    s_raw = {1'b0, mb_x} - {1'b0, ms_sh};

    if (s_raw[27]) begin
      s_al = {s_raw[27:2], s_raw[1] | s_raw[0]};
      e_al = {1'b0, eb} + 9'd1;
    end else begin
      s_al = s_raw[26:0];
      e_al = {1'b0, eb};
    end

    // Leading zero count for cancellation
    lz = 5'd0;
    lz_found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!lz_found && s_al[i]) begin
        lz = 5'(26 - i);
        lz_found = 1'b1;
      end
    end
    shamt = ({4'd0, lz} < e_al) ? {4'd0, lz} : (e_al - 9'd1);
    m_n = s_al << shamt;
    e_n = e_al - shamt;

    // Pack and round; mantissa carry ripples into the exponent
    packed_v = {(m_n[26] ? e_n[7:0] : 8'd0), m_n[25:3]};
    rnd_up   = m_n[2] & (m_n[1] | m_n[0] | m_n[3]);
    rounded  = packed_v + {30'd0, rnd_up};

    // Special cases
    if (is_nan(a) || is_nan(b) || (a_inf && b_inf && (a[31] != b[31]))) begin
      sum = CANON_QNAN;
    end else if (a_inf || b_inf) begin
      sum = a_inf ? a : b;
    end else if (s_raw == 28'd0) begin
      sum = {big[31] & sml[31], 31'd0};
    end else if (e_al >= 9'd255) begin
      sum = {big[31], 8'hFF, 23'd0};
    end else begin
      sum = {big[31], rounded};
    end
  end

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for float_vector_sum_reduce: directed and random groups
// against a bit-exact binary32 predictor. Depends on fvsr_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import fvsr_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 152;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [31:0]         in_value_bits;
  logic                out_valid;
  logic                out_ready;
  logic [31:0]         out_sum_bits;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;

  // Predictor state
  logic [CFG_W-1:0]    group_size;
  logic [31:0]         partial_sum;
  logic [CNT_W-1:0]    values_taken;
  logic [31:0]         expected_sums[$];

  int unsigned mismatches;
  int unsigned sums_checked;
  int unsigned values_sent;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          sender_busy;
  bit          sender_burst;
  bit          receiver_free;

  float_vector_sum_reduce DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value_bits (in_value_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sum_bits  (out_sum_bits),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Binary32 addition, round to nearest even, subnormals kept
  function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] hi, lo;
    logic [23:0] m_hi, m_lo, mant;
    logic [24:0] mant_r;
    logic [26:0] big, sml;
    logic [27:0] r;
    int          e_hi, e_lo, d, e;
    logic        sticky, up;
    if (is_nan(a) || is_nan(b)) return CANON_QNAN;
    if (a[30:23] == 8'hFF) begin
      if (b[30:23] == 8'hFF && a[31] != b[31]) return CANON_QNAN;
      return a;
    end
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] >= b[30:0]) begin
      hi = a; lo = b;
    end else begin
      hi = b; lo = a;
    end
    e_hi = (hi[30:23] == 0) ? 1 : int'(hi[30:23]);
    e_lo = (lo[30:23] == 0) ? 1 : int'(lo[30:23]);
    m_hi = {hi[30:23] != 0, hi[22:0]};
    m_lo = {lo[30:23] != 0, lo[22:0]};
    big = {m_hi, 3'b000};
    sml = {m_lo, 3'b000};
    d = e_hi - e_lo;
    if (d >= 27) begin
      sml = (m_lo != 0) ? 27'd1 : 27'd0;
    end else if (d > 0) begin
      sticky = |(sml & ((27'd1 << d) - 27'd1));
      sml = (sml >> d) | sticky;
    end
    r = (hi[31] == lo[31]) ? {1'b0, big} + sml : {1'b0, big} - sml;
    if (r == 0) return {hi[31] & lo[31], 31'd0};
    e = e_hi;
    if (r[27]) begin
      r = (r >> 1) | r[0];
      e = e + 1;
    end else begin
      while (!r[26] && e > 1) begin
        r = r << 1;
        e = e - 1;
      end
    end
    mant = r[26:3];
    up = r[2] && (r[1] || r[0] || mant[0]);
    mant_r = mant + up;
    if (mant_r[24]) begin
      mant = 24'h800000;
      e = e + 1;
    end else begin
      mant = mant_r[23:0];
    end
    if (e >= 255) return {hi[31], 8'hFF, 23'd0};
    return {hi[31], mant[23] ? 8'(e) : 8'd0, mant[22:0]};
  endfunction

  // Fold one accepted value into the running group sum
  task automatic accumulate_value(input logic [31:0] v);
    logic [31:0] s;
    if (group_size < 1 || group_size > MAX_VECTORS) return;
    s = (values_taken == 0) ? v : fp32_add(partial_sum, v);
    partial_sum = s;
    if (32'(values_taken) + 1 >= 32'(group_size)) begin
      expected_sums = {expected_sums, (is_nan(s) ? CANON_QNAN : s)};
      values_taken = '0;
    end else begin
      values_taken = values_taken + 1'b1;
    end
  endtask

  // Mostly short gaps, a few long ones, none during bursts
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_burst) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // Offer one value and hold it until the transfer
  task automatic send_value(input logic [31:0] v);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_value_bits <= v;
    do @(posedge clk); while (!in_ready);
    accumulate_value(v);
    values_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Let pending sums drain, then write the group size
  task automatic write_group_size(input logic [CFG_W-1:0] n);
    release_input();
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    group_size = n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] specials[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                  32'hFF80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                                  32'h0000_0001, 32'h807F_FFFF, 32'h7FC0_0000,
                                  32'h3F80_0000};
    logic        s;
    logic [22:0] m;
    s = 1'($urandom);
    m = 23'($urandom);
    case ($urandom_range(9))
      6:       return $urandom;
      7:       return specials[$urandom_range(9)];
      8:       return {s, 8'($urandom_range(3)), m};
      9:       return {s, 8'($urandom_range(254, 250)), m};
      default: return {s, 8'($urandom_range(140, 110)), m};
    endcase
  endfunction

  // Receiver: random readiness, free-running stretches, long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (receiver_free) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) < 65) ? 1'b1 : ($urandom_range(99) < 90);
    end
  end

  // Check each result transfer against the oldest expected sum
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected sum 0x%08h at %0t", out_sum_bits, $realtime);
      end else begin
        if (out_sum_bits !== expected_sums[0]) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("sum mismatch: expected 0x%08h actual 0x%08h at %0t",
                     expected_sums[0], out_sum_bits, $realtime);
        end
        void'(expected_sums.pop_front());
        sums_checked++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n && (sender_busy || expected_sums.size() != 0) &&
        !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", idle_cycles);
        $display("** float_vector_sum_reduce: FAILED **");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Single-value groups across the edges of the value field
  task automatic test_single_groups();
    logic [31:0] vals[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                              32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF,
                              32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                              32'h5555_AAAA};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Pairs: opposite infinities, overflow, cancellation, signed zeros, subnormals, a signalling NaN
  task automatic test_special_pairs();
    write_group_size(5'd2);
    send_value(32'h7F80_0000); send_value(32'hFF80_0000);
    send_value(32'h7F7F_FFFF); send_value(32'h7F7F_FFFF);
    send_value(32'h3F80_0000); send_value(32'hBF80_0000);
    send_value(32'h8000_0000); send_value(32'h8000_0000);
    send_value(32'h0040_0000); send_value(32'h0040_0000);
    send_value(32'h7FA0_0000); send_value(32'h3F80_0000);
  endtask

  // Out-of-range group sizes make the block drop its input
  task automatic test_bad_sizes();
    write_group_size(5'd0);
    send_value(32'h3F80_0000);
    write_group_size(5'd17);
    send_value(32'h4000_0000);
    write_group_size(5'd31);
    send_value(32'h4040_0000);
  endtask

  // Lower the size mid-group so the next value closes it
  task automatic test_lowered_size();
    write_group_size(5'd16);
    repeat (3) send_value(random_value());
    write_group_size(5'd2);
    send_value(32'h4080_0000);
  endtask

  // Random groups over a range of sizes, one phase with a long receiver hold-off
  task automatic test_random_groups();
    logic [CFG_W-1:0] sizes[RAND_PHASES] = '{5'd1, 5'd16, 5'd2, 5'd3, 5'd5, 5'd1,
                                            5'd7, 5'd16, 5'd4, 5'd11, 5'd2, 5'd1};
    foreach (sizes[p]) begin
      write_group_size(sizes[p]);
      sender_burst  = (p % 4 == 1);
      receiver_free = (p % 4 == 2);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == 10) stall_left = 400;
        send_value(random_value());
      end
    end
    sender_burst  = 1'b0;
    receiver_free = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value_bits = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    group_size    = 5'd1;
    partial_sum   = '0;
    values_taken  = '0;
    mismatches    = 0;
    sums_checked  = 0;
    values_sent   = 0;
    idle_cycles   = 0;
    stall_left    = 0;
    sender_busy   = 1'b1;
    sender_burst  = 1'b0;
    receiver_free = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_groups();
    test_special_pairs();
    test_bad_sizes();
    test_lowered_size();
    test_random_groups();

    release_input();
    sender_busy = 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d values and %0d group sums, sizes 0..31 incl. out of range,",
             values_sent, sums_checked);
    $display("special floats, mid-group size change and a long output stall");
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("** float_vector_sum_reduce: PASSED **");
    end else begin
      $display("** float_vector_sum_reduce: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
src/fvsr_pkg.sv
src/fvsr_fadd.sv
src/float_vector_sum_reduce.sv
bench/testbench.sv
